[rtl/tpc_pkg.sv]
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared types, constants and the microprogram of the compensation unit.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int unsigned PcW = 6;
  localparam logic [PcW-1:0] PC_TEMP = 6'd0;
  localparam logic [PcW-1:0] PC_PRES = 6'd16;

  localparam logic [63:0] K_128000 = 64'd128000;
  localparam logic [63:0] K_2P47   = 64'd1 << 47;
  localparam logic [63:0] K_1M     = 64'd1048576;
  localparam logic [63:0] K_3125   = 64'd3125;
  localparam logic [63:0] K_5      = 64'd5;
  localparam logic [63:0] K_128    = 64'd128;

  localparam logic [3:0] REG_T1 = 4'd0;
  localparam logic [3:0] REG_T2 = 4'd1;
  localparam logic [3:0] REG_T3 = 4'd2;
  localparam logic [3:0] REG_P1 = 4'd3;
  localparam logic [3:0] REG_P23 = 4'd4;
  localparam logic [3:0] REG_P45 = 4'd5;
  localparam logic [3:0] REG_P67 = 4'd6;
  localparam logic [3:0] REG_P89 = 4'd7;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_ASR, OP_MUL, OP_DIV, OP_RND, OP_STFT, OP_CHKZ, OP_DONE
  } op_e;

  typedef enum logic [4:0] {
    S_R0, S_R1, S_R2, S_R3, S_R4, S_RAW, S_FT, S_ZERO,
    S_T1, S_T2, S_T3, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_K128000, S_K2P47, S_K1M, S_K3125, S_K5, S_K128
  } src_e;

  typedef enum logic [2:0] {
    D_R0, D_R1, D_R2, D_R3, D_R4
  } dst_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_EXEC, ST_WAIT, ST_DONE
  } state_e;

  typedef struct packed {
    op_e        op;
    dst_e       dst;
    src_e       src_a;
    src_e       src_b;
    logic [5:0] sh;
  } uinst_t;

  typedef struct packed {
    logic   load_item;
    logic   issue;
    logic   wb;
    logic   out_load;
    uinst_t inst;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic a_zero;
    logic out_free;
  } dp_sts_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [31:0] p23;
    logic [31:0] p45;
    logic [31:0] p67;
    logic [31:0] p89;
  } cal_t;

  function automatic uinst_t ui(op_e op, dst_e dst, src_e a, src_e b, logic [5:0] sh);
    uinst_t u;
    u.op    = op;
    u.dst   = dst;
    u.src_a = a;
    u.src_b = b;
    u.sh    = sh;
    return u;
  endfunction

  // temperature at PC_TEMP, pressure at PC_PRES
  function automatic uinst_t prog(logic [PcW-1:0] pc);
    uinst_t u;
    case (pc)
      6'd0:  u = ui(OP_ASR,  D_R0, S_RAW,  S_ZERO, 6'd3);
      6'd1:  u = ui(OP_SUB,  D_R0, S_R0,   S_T1,   6'd1);
      6'd2:  u = ui(OP_MUL,  D_R0, S_R0,   S_T2,   6'd0);
      6'd3:  u = ui(OP_ASR,  D_R0, S_R0,   S_ZERO, 6'd11);
      6'd4:  u = ui(OP_ASR,  D_R1, S_RAW,  S_ZERO, 6'd4);
      6'd5:  u = ui(OP_SUB,  D_R1, S_R1,   S_T1,   6'd0);
      6'd6:  u = ui(OP_MUL,  D_R1, S_R1,   S_R1,   6'd0);
      6'd7:  u = ui(OP_ASR,  D_R1, S_R1,   S_ZERO, 6'd12);
      6'd8:  u = ui(OP_MUL,  D_R1, S_R1,   S_T3,   6'd0);
      6'd9:  u = ui(OP_ASR,  D_R1, S_R1,   S_ZERO, 6'd14);
      6'd10: u = ui(OP_ADD,  D_R0, S_R0,   S_R1,   6'd0);
      6'd11: u = ui(OP_STFT, D_R0, S_R0,   S_ZERO, 6'd0);
      6'd12: u = ui(OP_MUL,  D_R0, S_FT,   S_K5,   6'd0);
      6'd13: u = ui(OP_ADD,  D_R0, S_R0,   S_K128, 6'd0);
      6'd14: u = ui(OP_ASR,  D_R0, S_R0,   S_ZERO, 6'd8);
      6'd15: u = ui(OP_DONE, D_R0, S_R0,   S_ZERO, 6'd0);
      6'd16: u = ui(OP_SUB,  D_R0, S_FT,   S_K128000, 6'd0);
      6'd17: u = ui(OP_MUL,  D_R1, S_R0,   S_R0,   6'd0);
      6'd18: u = ui(OP_MUL,  D_R2, S_R1,   S_P6,   6'd0);
      6'd19: u = ui(OP_MUL,  D_R3, S_R0,   S_P5,   6'd0);
      6'd20: u = ui(OP_ADD,  D_R2, S_R2,   S_R3,   6'd17);
      6'd21: u = ui(OP_ADD,  D_R2, S_R2,   S_P4,   6'd35);
      6'd22: u = ui(OP_MUL,  D_R3, S_R1,   S_P3,   6'd0);
      6'd23: u = ui(OP_ASR,  D_R3, S_R3,   S_ZERO, 6'd8);
      6'd24: u = ui(OP_MUL,  D_R4, S_R0,   S_P2,   6'd0);
      6'd25: u = ui(OP_ADD,  D_R0, S_R3,   S_R4,   6'd12);
      6'd26: u = ui(OP_ADD,  D_R0, S_R0,   S_K2P47, 6'd0);
      6'd27: u = ui(OP_MUL,  D_R0, S_R0,   S_P1,   6'd0);
      6'd28: u = ui(OP_ASR,  D_R0, S_R0,   S_ZERO, 6'd33);
      6'd29: u = ui(OP_CHKZ, D_R0, S_R0,   S_ZERO, 6'd0);
      6'd30: u = ui(OP_SUB,  D_R1, S_K1M,  S_RAW,  6'd0);
      6'd31: u = ui(OP_ADD,  D_R1, S_ZERO, S_R1,   6'd31);
      6'd32: u = ui(OP_SUB,  D_R1, S_R1,   S_R2,   6'd0);
      6'd33: u = ui(OP_MUL,  D_R1, S_R1,   S_K3125, 6'd0);
      6'd34: u = ui(OP_DIV,  D_R1, S_R1,   S_R0,   6'd0);
      6'd35: u = ui(OP_ASR,  D_R2, S_R1,   S_ZERO, 6'd13);
      6'd36: u = ui(OP_MUL,  D_R3, S_P9,   S_R2,   6'd0);
      6'd37: u = ui(OP_MUL,  D_R3, S_R3,   S_R2,   6'd0);
      6'd38: u = ui(OP_ASR,  D_R3, S_R3,   S_ZERO, 6'd25);
      6'd39: u = ui(OP_MUL,  D_R4, S_P8,   S_R1,   6'd0);
      6'd40: u = ui(OP_ASR,  D_R4, S_R4,   S_ZERO, 6'd19);
      6'd41: u = ui(OP_ADD,  D_R1, S_R1,   S_R3,   6'd0);
      6'd42: u = ui(OP_ADD,  D_R1, S_R1,   S_R4,   6'd0);
      6'd43: u = ui(OP_ASR,  D_R1, S_R1,   S_ZERO, 6'd8);
      6'd44: u = ui(OP_ADD,  D_R1, S_R1,   S_P7,   6'd4);
      6'd45: u = ui(OP_RND,  D_R1, S_R1,   S_ZERO, 6'd0);
      default: u = ui(OP_DONE, D_R1, S_R1, S_ZERO, 6'd0);
    endcase
    return u;
  endfunction

endpackage

[rtl/tpc_mul.sv]
// ----------------------------------------------------------------------------
// tpc_mul
// 64x64 multiplier, low 64 bits, built from one 32x32 multiplier that forms the partial products in turn.
// ----------------------------------------------------------------------------
module tpc_mul import tpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        busy_o,
  output logic [63:0] prod_o
);

  logic [63:0] a_q, b_q, pp_q, pp_d, acc_q, acc_d;
  logic [1:0]  cnt_q;
  logic        busy_q;
  logic [31:0] ma, mb;

  always_comb begin
    case (cnt_q)
      2'd0:    begin ma = a_q[31:0];  mb = b_q[31:0];  end
      2'd1:    begin ma = a_q[31:0];  mb = b_q[63:32]; end
      default: begin ma = a_q[63:32]; mb = b_q[31:0];  end
    endcase
    pp_d = {32'd0, ma} * {32'd0, mb};
    case (cnt_q)
      2'd0:    acc_d = acc_q;
      2'd1:    acc_d = pp_q;
      default: acc_d = acc_q + {pp_q[31:0], 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 2'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 2'd1;
      if (cnt_q == 2'd3) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (busy_q) begin
      pp_q  <= pp_d;
      acc_q <= acc_d;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

[rtl/tpc_div.sv]
// ----------------------------------------------------------------------------
// tpc_div
// Signed 64-bit divider truncating toward zero, restoring, one bit per cycle.
// ----------------------------------------------------------------------------
module tpc_div import tpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        busy_o,
  output logic [63:0] quo_o
);

  logic [63:0] rem_q, quo_q, md_q;
  logic        neg_q, busy_q;
  logic [5:0]  cnt_q;
  logic [64:0] trial, diff;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, md_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 64'd0;
      quo_q <= a_i[63] ? (64'd0 - a_i) : a_i;
      md_q  <= b_i[63] ? (64'd0 - b_i) : b_i;
      neg_q <= a_i[63] ^ b_i[63];
    end else if (busy_q) begin
      // shift in the next dividend bit, keep the partial remainder
      if (!diff[64]) begin
        rem_q <= diff[63:0];
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= trial[63:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = neg_q ? (64'd0 - quo_q) : quo_q;

endmodule

[rtl/tpc_ctrl.sv]
// ----------------------------------------------------------------------------
// tpc_ctrl
// Microprogram sequencer: steps through the temperature or pressure program.
// ----------------------------------------------------------------------------
module tpc_ctrl import tpc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    func_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e       state_q, state_d;
  logic [PcW-1:0] pc_q, pc_d;
  uinst_t       inst;

  assign inst = prog(pc_q);

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
          pc_d    = func_i ? PC_PRES : PC_TEMP;
        end
      end
      ST_EXEC: begin
        case (inst.op)
          OP_MUL, OP_DIV: begin
            state_d = ST_WAIT;
            pc_d    = pc_q + 6'd1;
          end
          OP_CHKZ: begin
            if (sts_i.a_zero) state_d = ST_DONE;
            else pc_d = pc_q + 6'd1;
          end
          OP_DONE: state_d = ST_DONE;
          default: pc_d = pc_q + 6'd1;
        endcase
      end
      ST_WAIT: begin
        if (!sts_i.busy) state_d = ST_EXEC;
      end
      ST_DONE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o      = 1'b1;
    cmd_o           = '0;
    cmd_o.inst      = inst;
    case (state_q)
      ST_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      ST_EXEC: cmd_o.issue    = 1'b1;
      ST_WAIT: cmd_o.wb       = !sts_i.busy;
      ST_DONE: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= PC_TEMP;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

endmodule

[rtl/tpc_dp.sv]
// ----------------------------------------------------------------------------
// tpc_dp
// Datapath: working registers, ALU, shared multiplier and divider, result reg.
// ----------------------------------------------------------------------------
module tpc_dp import tpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  cal_t        cal_i,
  input  logic        func_i,
  input  logic [19:0] raw_reading_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic signed [31:0] value_o,
  output logic        div_zero_o
);

  logic [63:0] r0_q, r1_q, r2_q, r3_q, r4_q;
  logic [19:0] raw_q;
  logic        kind_q, dz_q, pend_div_q;
  dst_e        pend_dst_q;
  logic [31:0] ft_q;
  logic        out_valid_q, out_kind_q, out_dz_q;
  logic [31:0] out_value_q;

  logic [63:0] opa, opb, alu, wr_data, mul_p, div_q, rnd_in;
  logic        wr_en, mul_busy, div_busy;
  dst_e        wr_dst;
  uinst_t      inst;

  assign inst = cmd_i.inst;

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] pick(src_e s, logic [63:0] r0, logic [63:0] r1,
                                      logic [63:0] r2, logic [63:0] r3,
                                      logic [63:0] r4, logic [19:0] raw,
                                      logic [31:0] ft, cal_t c);
    logic [63:0] v;
    case (s)
      S_R0:      v = r0;
      S_R1:      v = r1;
      S_R2:      v = r2;
      S_R3:      v = r3;
      S_R4:      v = r4;
      S_RAW:     v = {44'd0, raw};
      S_FT:      v = {{32{ft[31]}}, ft};
      S_T1:      v = {48'd0, c.t1};
      S_T2:      v = sx16(c.t2);
      S_T3:      v = sx16(c.t3);
      S_P1:      v = {48'd0, c.p1};
      S_P2:      v = sx16(c.p23[15:0]);
      S_P3:      v = sx16(c.p23[31:16]);
      S_P4:      v = sx16(c.p45[15:0]);
      S_P5:      v = sx16(c.p45[31:16]);
      S_P6:      v = sx16(c.p67[15:0]);
      S_P7:      v = sx16(c.p67[31:16]);
      S_P8:      v = sx16(c.p89[15:0]);
      S_P9:      v = sx16(c.p89[31:16]);
      S_K128000: v = K_128000;
      S_K2P47:   v = K_2P47;
      S_K1M:     v = K_1M;
      S_K3125:   v = K_3125;
      S_K5:      v = K_5;
      S_K128:    v = K_128;
      default:   v = 64'd0;
    endcase
    return v;
  endfunction

  assign opa = pick(inst.src_a, r0_q, r1_q, r2_q, r3_q, r4_q, raw_q, ft_q, cal_i);
  assign opb = pick(inst.src_b, r0_q, r1_q, r2_q, r3_q, r4_q, raw_q, ft_q, cal_i);

  // divide by 256 toward zero: bias negative values before the shift
  assign rnd_in = opa[63] ? (opa + 64'd255) : opa;

  always_comb begin
    case (inst.op)
      OP_ADD:  alu = opa + (opb << inst.sh);
      OP_SUB:  alu = opa - (opb << inst.sh);
      OP_ASR:  alu = 64'($signed(opa) >>> inst.sh);
      OP_RND:  alu = 64'($signed(rnd_in) >>> 8);
      default: alu = opa;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_dst  = inst.dst;
    wr_data = alu;
    if (cmd_i.wb) begin
      wr_en   = 1'b1;
      wr_dst  = pend_dst_q;
      wr_data = pend_div_q ? div_q : mul_p;
    end else if (cmd_i.issue) begin
      wr_en = (inst.op == OP_ADD) || (inst.op == OP_SUB) ||
              (inst.op == OP_ASR) || (inst.op == OP_RND);
    end
  end

  tpc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.issue && (inst.op == OP_MUL)),
    .a_i     (opa),
    .b_i     (opb),
    .busy_o  (mul_busy),
    .prod_o  (mul_p)
  );

  tpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.issue && (inst.op == OP_DIV)),
    .a_i     (opa),
    .b_i     (opb),
    .busy_o  (div_busy),
    .quo_o   (div_q)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (wr_dst)
        D_R0:    r0_q <= wr_data;
        D_R1:    r1_q <= wr_data;
        D_R2:    r2_q <= wr_data;
        D_R3:    r3_q <= wr_data;
        D_R4:    r4_q <= wr_data;
        default: ;
      endcase
    end
    if (cmd_i.issue && ((inst.op == OP_MUL) || (inst.op == OP_DIV))) begin
      pend_dst_q <= inst.dst;
      pend_div_q <= (inst.op == OP_DIV);
    end
    if (cmd_i.load_item) begin
      raw_q  <= raw_reading_i;
      kind_q <= func_i;
    end
    if (cmd_i.out_load) begin
      out_value_q <= opa[31:0];
      out_kind_q  <= kind_q;
      out_dz_q    <= dz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ft_q        <= 32'd0;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.issue && (inst.op == OP_STFT)) ft_q <= opa[31:0];
      if (cmd_i.load_item) dz_q <= 1'b0;
      else if (cmd_i.issue && (inst.op == OP_CHKZ) && (opa == 64'd0)) dz_q <= 1'b1;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign sts_o.busy     = mul_busy || div_busy;
  assign sts_o.a_zero   = (opa == 64'd0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_kind_q;
  assign value_o     = out_value_q;
  assign div_zero_o  = out_dz_q;

endmodule

[rtl/temp_pressure_compensation_unit.sv]
// ----------------------------------------------------------------------------
// temp_pressure_compensation_unit
// Integer temperature and pressure compensation with calibration registers.
// ----------------------------------------------------------------------------
// One request at a time. Every 64-bit multiply runs on one shared 32x32
// multiplier and the pressure division in a one-bit-per-cycle divider, each
// with an issue and a write-back step; every other step is a single
// microinstruction. A temperature request updates the stored fine
// temperature used by later pressure requests; a pressure request with a
// zero divisor stops before the division and returns 0 with div_zero set.
// A finished result waits in the output register while the next request is
// accepted. Calibration writes are always ready.
module temp_pressure_compensation_unit import tpc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [19:0]        raw_reading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic signed [31:0] value_o,
  output logic               div_zero_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cal_t    cal_q;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_T1:  cal_q.t1  <= cfg_data_i[15:0];
        REG_T2:  cal_q.t2  <= cfg_data_i[15:0];
        REG_T3:  cal_q.t3  <= cfg_data_i[15:0];
        REG_P1:  cal_q.p1  <= cfg_data_i[15:0];
        REG_P23: cal_q.p23 <= cfg_data_i;
        REG_P45: cal_q.p45 <= cfg_data_i;
        REG_P67: cal_q.p67 <= cfg_data_i;
        REG_P89: cal_q.p89 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cal_i         (cal_q),
    .func_i        (func_i),
    .raw_reading_i (raw_reading_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .value_o       (value_o),
    .div_zero_o    (div_zero_o)
  );

endmodule

[test/tb_temp_pressure_compensation_unit.sv]
// ----------------------------------------------------------------------------
// tb_temp_pressure_compensation_unit
// Drives temperature and pressure requests through the compensation unit under
// several calibration sets, predicts each result with a local integer model
// and compares kind, value and div_zero in order, with random idling on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_temp_pressure_compensation_unit import tpc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FUNC_TEMP = 1'b0;
  localparam logic FUNC_PRES = 1'b1;
  localparam int NUM_RANDOM = 600;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        div_zero;
  } comp_result_t;

  typedef struct {
    logic        func;
    logic [19:0] raw;
    logic        known;
    logic [31:0] value;
    logic        div_zero;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic [19:0] raw_reading_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic kind_o;
  logic signed [31:0] value_o;
  logic div_zero_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [3:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // predictor copy of the calibration and stored fine temperature
  cal_t cal_words;
  logic [31:0] fine_temp_q;

  comp_result_t pending_results[$];
  comp_result_t known_results[$];
  logic known_flags[$];
  int err_count = 0;
  bit quiet_phase = 0;
  bit long_hold = 0;

  always #5 clk_i = ~clk_i;

  temp_pressure_compensation_unit u_top (.*);

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] div_trunc(logic [63:0] a, logic [63:0] d);
    logic [63:0] ma, md, q;
    ma = a[63] ? -a : a;
    md = d[63] ? -d : d;
    q = ma / md;
    return (a[63] != d[63]) ? -q : q;
  endfunction

  function automatic comp_result_t compensate(logic func, logic [19:0] raw);
    comp_result_t r;
    logic [63:0] rw, t1, a, d, b, t, v1, v2, p, h;
    rw = {44'd0, raw};
    r.kind = func;
    r.div_zero = 1'b0;
    if (func == FUNC_TEMP) begin
      t1 = {48'd0, cal_words.t1};
      a = asr64(((rw >> 3) - (t1 << 1)) * sx16(cal_words.t2), 11);
      d = (rw >> 4) - t1;
      b = asr64(asr64(d * d, 12) * sx16(cal_words.t3), 14);
      fine_temp_q = a[31:0] + b[31:0];
      t = {{32{fine_temp_q[31]}}, fine_temp_q};
      t = asr64(t * 64'd5 + 64'd128, 8);
      r.value = t[31:0];
    end else begin
      v1 = {{32{fine_temp_q[31]}}, fine_temp_q} - 64'd128000;
      v2 = v1 * v1 * sx16(cal_words.p67[15:0]);
      v2 = v2 + ((v1 * sx16(cal_words.p45[31:16])) << 17);
      v2 = v2 + (sx16(cal_words.p45[15:0]) << 35);
      v1 = asr64(v1 * v1 * sx16(cal_words.p23[31:16]), 8)
           + ((v1 * sx16(cal_words.p23[15:0])) << 12);
      v1 = asr64(((64'd1 << 47) + v1) * {48'd0, cal_words.p1}, 33);
      if (v1 == 0) begin
        r.div_zero = 1'b1;
        r.value = '0;
      end else begin
        p = 64'd1048576 - rw;
        p = div_trunc(((p << 31) - v2) * 64'd3125, v1);
        h = asr64(p, 13);
        v1 = asr64(sx16(cal_words.p89[31:16]) * h * h, 25);
        v2 = asr64(sx16(cal_words.p89[15:0]) * p, 19);
        p = asr64(p + v1 + v2, 8) + (sx16(cal_words.p67[31:16]) << 4);
        p = div_trunc(p, 64'd256);
        r.value = p[31:0];
      end
    end
    return r;
  endfunction

  // valid stays high afterwards; the caller drops it
  task automatic write_cal(logic [3:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_T1:  cal_words.t1 = data[15:0];
      REG_T2:  cal_words.t2 = data[15:0];
      REG_T3:  cal_words.t3 = data[15:0];
      REG_P1:  cal_words.p1 = data[15:0];
      REG_P23: cal_words.p23 = data;
      REG_P45: cal_words.p45 = data;
      REG_P67: cal_words.p67 = data;
      REG_P89: cal_words.p89 = data;
      default: ;
    endcase
  endtask

  task automatic load_cal_set(cal_t c);
    write_cal(REG_T1, {16'd0, c.t1});
    write_cal(REG_T2, {16'd0, c.t2});
    write_cal(REG_T3, {16'd0, c.t3});
    write_cal(REG_P1, {16'd0, c.p1});
    write_cal(REG_P23, c.p23);
    write_cal(REG_P45, c.p45);
    write_cal(REG_P67, c.p67);
    write_cal(REG_P89, c.p89);
    cfg_valid_i <= 1'b0;
  endtask

  // one request; known marks a typed-in expectation
  task automatic send_request(logic func, logic [19:0] raw, logic known,
                              logic [31:0] value, logic dz);
    comp_result_t r;
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= func;
    raw_reading_i <= raw;
    do @(posedge clk_i); while (in_stall_o);
    r = compensate(func, raw);
    pending_results.push_back(r);
    known_flags.push_back(known);
    known_results.push_back('{kind: func, value: value, div_zero: dz});
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // receiver stall process
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (2000) @(posedge clk_i);
        long_hold = 0;
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    comp_result_t exp_r, typed;
    logic known;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result kind=%0d value=%0d", kind_o, value_o);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        known = known_flags.pop_front();
        typed = known_results.pop_front();
        if (known && typed != exp_r) begin
          $error("table row disagrees with prediction: %h vs %h", typed, exp_r);
          err_count++;
        end
        if (kind_o !== exp_r.kind) begin
          $error("kind: expected %0d actual %0d", exp_r.kind, kind_o);
          err_count++;
        end
        if (value_o !== exp_r.value) begin
          $error("value: expected %0d actual %0d", $signed(exp_r.value), value_o);
          err_count++;
        end
        if (div_zero_o !== exp_r.div_zero) begin
          $error("div_zero: expected %0d actual %0d", exp_r.div_zero, div_zero_o);
          err_count++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    cal_t c;
    logic func;
    logic [19:0] raw;
    cal_words = '0;
    fine_temp_q = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset all words are zero: p1 of zero makes a zero divisor
    rows.push_back('{FUNC_PRES, 20'd0, 1'b1, 32'd0, 1'b1});
    rows.push_back('{FUNC_PRES, 20'hFFFFF, 1'b1, 32'd0, 1'b1});
    // zero calibration: fine temperature 0 -> (0*5+128)>>8 = 0
    rows.push_back('{FUNC_TEMP, 20'd0, 1'b1, 32'd0, 1'b0});
    rows.push_back('{FUNC_TEMP, 20'hFFFFF, 1'b1, 32'd0, 1'b0});
    foreach (rows[i])
      send_request(rows[i].func, rows[i].raw, rows[i].known, rows[i].value, rows[i].div_zero);
    wait_drained();

    // typical calibration, then predictor-checked rows
    c = '{t1: 16'd27504, t2: 16'd26435, t3: 16'hFC18, p1: 16'd36477,
          p23: {16'd3024, 16'hD6D0}, p45: {16'hFF60, 16'd2855},
          p67: {16'd15500, 16'hFFF9}, p89: {16'd6000, 16'hC1F0}};
    load_cal_set(c);
    send_request(FUNC_PRES, 20'd415148, 0, '0, 0);
    send_request(FUNC_TEMP, 20'd519888, 0, '0, 0);
    send_request(FUNC_PRES, 20'd415148, 0, '0, 0);
    send_request(FUNC_TEMP, 20'h00000, 0, '0, 0);
    send_request(FUNC_PRES, 20'hFFFFF, 0, '0, 0);
    send_request(FUNC_TEMP, 20'hFFFFF, 0, '0, 0);
    send_request(FUNC_PRES, 20'h00000, 0, '0, 0);
    send_request(FUNC_PRES, 20'hAAAAA, 0, '0, 0);
    send_request(FUNC_PRES, 20'h55555, 0, '0, 0);
    wait_drained();

    // extreme calibrations
    load_cal_set('{t1: 16'hFFFF, t2: 16'h7FFF, t3: 16'h7FFF, p1: 16'hFFFF,
                   p23: 32'h7FFF7FFF, p45: 32'h7FFF7FFF, p67: 32'h7FFF7FFF,
                   p89: 32'h7FFF7FFF});
    send_request(FUNC_TEMP, 20'hFFFFF, 0, '0, 0);
    send_request(FUNC_PRES, 20'd0, 0, '0, 0);
    send_request(FUNC_TEMP, 20'd0, 0, '0, 0);
    send_request(FUNC_PRES, 20'hFFFFF, 0, '0, 0);
    wait_drained();
    load_cal_set('{t1: 16'h0000, t2: 16'h8000, t3: 16'h8000, p1: 16'h0001,
                   p23: 32'h80008000, p45: 32'h80008000, p67: 32'h80008000,
                   p89: 32'h80008000});
    send_request(FUNC_TEMP, 20'hFFFFF, 0, '0, 0);
    send_request(FUNC_PRES, 20'h12345, 0, '0, 0);
    send_request(FUNC_TEMP, 20'd1, 0, '0, 0);
    send_request(FUNC_PRES, 20'hFFFFF, 0, '0, 0);
    wait_drained();
    // out-of-range index is ignored
    write_cal(4'd9, 32'hFFFFFFFF);
    write_cal(4'd15, 32'h12345678);

    // random phases: half with realistic calibration, half fully random
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) begin
        c.t1 = 16'($urandom_range(20000, 35000));
        c.t2 = 16'($urandom_range(20000, 30000));
        c.t3 = -16'($urandom_range(0, 2000));
        c.p1 = 16'($urandom_range(30000, 40000));
        c.p23 = {16'($urandom_range(0, 5000)), -16'($urandom_range(9000, 12000))};
        c.p45 = {-16'($urandom_range(0, 500)), 16'($urandom_range(0, 9000))};
        c.p67 = {16'($urandom_range(0, 16000)), -16'($urandom_range(0, 10))};
        c.p89 = {16'($urandom_range(0, 9000)), -16'($urandom_range(0, 17000))};
      end else begin
        c = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      end
      if (ph == 3) c.p1 = 16'd0;
      load_cal_set(c);
      if (ph == 2) long_hold = 1;
      if (ph == 5) quiet_phase = 1;
      for (int n = 0; n < NUM_RANDOM / 6; n++) begin
        func = ($urandom_range(0, 2) != 0) ? FUNC_PRES : FUNC_TEMP;
        raw = (ph % 2 == 0 && $urandom_range(0, 4) != 0)
              ? 20'($urandom_range(250000, 600000)) : 20'($urandom());
        send_request(func, raw, 0, '0, 0);
      end
      wait_drained();
    end

    if (err_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[temp_pressure_compensation_unit.f]
rtl/tpc_pkg.sv
rtl/tpc_mul.sv
rtl/tpc_div.sv
rtl/tpc_ctrl.sv
rtl/tpc_dp.sv
rtl/temp_pressure_compensation_unit.sv
test/tb_temp_pressure_compensation_unit.sv
